/* design/tbb_pkg.sv */
`default_nettype none
package tbb_pkg;

  // Coordinate and matrix formats
  localparam int COORD_WIDTH = 16;
  localparam int COORD_FRAC  = 8;
  localparam int MAT_WIDTH   = 16;
  localparam int MAT_FRAC    = 12;

  // Register indexes of the configuration port
  localparam int CFG_IDX_WIDTH = 3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_BOX_MAX_Z = 3'd5;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [MAT_WIDTH-1:0]   mat_t;

  // One transform request: top three rows of the affine matrix
  typedef struct packed {
    mat_t   m_xx;
    mat_t   m_xy;
    mat_t   m_xz;
    coord_t t_x;
    mat_t   m_yx;
    mat_t   m_yy;
    mat_t   m_yz;
    coord_t t_y;
    mat_t   m_zx;
    mat_t   m_zy;
    mat_t   m_zz;
    coord_t t_z;
  } tbb_req_t;

  // One bounds result
  typedef struct packed {
    coord_t out_min_x;
    coord_t out_max_x;
    coord_t out_min_y;
    coord_t out_max_y;
    coord_t out_min_z;
    coord_t out_max_z;
    logic   saturated;
  } tbb_res_t;

endpackage
`default_nettype wire

/* design/transformed_box_bounds.sv */
// The done strobe and the result leave the output register together; the result
// stays on the ports for one cycle only, while done is high.
// Throughput: one request per cycle; busy is low except during reset, and
// the four-stage multiply/select/sum/round pipeline never stalls.
// Reset (rst, synchronous): clears the box registers to zero and drops all
// requests in flight.
`default_nettype none
module transformed_box_bounds
  import tbb_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire tbb_req_t                 req,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [COORD_WIDTH-1:0]   cfg_data,
  output logic                          done,
  output tbb_res_t                      result
);

  localparam int PROD_W = MAT_WIDTH + COORD_WIDTH;
  localparam int ACC_W  = PROD_W + 2;
  localparam int RND_W  = ACC_W - MAT_FRAC;
  localparam int EXT_W  = ACC_W - COORD_WIDTH - MAT_FRAC;

  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (MAT_FRAC - 1);
  localparam logic signed [RND_W-1:0] CLAMP_HI = RND_W'(2 ** (COORD_WIDTH - 1) - 1);
  localparam logic signed [RND_W-1:0] CLAMP_LO = RND_W'(-(2 ** (COORD_WIDTH - 1)));

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [RND_W-1:0]  rnd_t;

  // Box registers
  coord_t box_lo [3];
  coord_t box_hi [3];

  // Unpacked request
  mat_t   m_in [3][3];
  coord_t t_in [3];

  // Stage 1: products with both box bounds
  logic   v1;
  prod_t  prod_lo [3][3];
  prod_t  prod_hi [3][3];
  coord_t t1 [3];

  // Stage 2: smaller and larger term per column
  logic   v2;
  prod_t  term_min [3][3];
  prod_t  term_max [3][3];
  coord_t t2 [3];

  // Stage 3: extreme accumulators per axis
  logic   v3;
  acc_t   acc_min [3];
  acc_t   acc_max [3];

  // Round and clamp ahead of the output register
  rnd_t   rnd_min [3];
  rnd_t   rnd_max [3];
  coord_t clp_min [3];
  coord_t clp_max [3];
  logic   sat_any;

  assign busy = rst;

  // Write box registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        box_lo[a] <= '0;
        box_hi[a] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_MIN_X: box_lo[0] <= cfg_data;
        REG_BOX_MIN_Y: box_lo[1] <= cfg_data;
        REG_BOX_MIN_Z: box_lo[2] <= cfg_data;
        REG_BOX_MAX_X: box_hi[0] <= cfg_data;
        REG_BOX_MAX_Y: box_hi[1] <= cfg_data;
        REG_BOX_MAX_Z: box_hi[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack request rows
  always_comb begin
    m_in[0][0] = req.m_xx; m_in[0][1] = req.m_xy; m_in[0][2] = req.m_xz;
    m_in[1][0] = req.m_yx; m_in[1][1] = req.m_yy; m_in[1][2] = req.m_yz;
    m_in[2][0] = req.m_zx; m_in[2][1] = req.m_zy; m_in[2][2] = req.m_zz;
    t_in[0] = req.t_x;
    t_in[1] = req.t_y;
    t_in[2] = req.t_z;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start && !busy;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  // Stage 1: multiply each entry by the lower and upper box coordinate
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        prod_lo[a][k] <= PROD_W'(m_in[a][k] * box_lo[k]);
        prod_hi[a][k] <= PROD_W'(m_in[a][k] * box_hi[k]);
      end
      t1[a] <= t_in[a];
    end
  end

  // Stage 2: sort each product pair; the extreme corner picks per column
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        if (prod_lo[a][k] < prod_hi[a][k]) begin
          term_min[a][k] <= prod_lo[a][k];
          term_max[a][k] <= prod_hi[a][k];
        end else begin
          term_min[a][k] <= prod_hi[a][k];
          term_max[a][k] <= prod_lo[a][k];
        end
      end
      t2[a] <= t1[a];
    end
  end

  // Stage 3: sum terms and the aligned translation
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      acc_min[a] <= ACC_W'(term_min[a][0]) + ACC_W'(term_min[a][1])
                  + ACC_W'(term_min[a][2])
                  + $signed({{EXT_W{t2[a][COORD_WIDTH-1]}}, t2[a], MAT_FRAC'(0)});
      acc_max[a] <= ACC_W'(term_max[a][0]) + ACC_W'(term_max[a][1])
                  + ACC_W'(term_max[a][2])
                  + $signed({{EXT_W{t2[a][COORD_WIDTH-1]}}, t2[a], MAT_FRAC'(0)});
    end
  end

  // Round half up, clamp, and flag any clamped corner
  always_comb begin
    acc_t sum_min;
    acc_t sum_max;
    sat_any = 1'b0;
    for (int a = 0; a < 3; a++) begin
      sum_min    = acc_min[a] + HALF_LSB;
      sum_max    = acc_max[a] + HALF_LSB;
      rnd_min[a] = $signed(sum_min[ACC_W-1:MAT_FRAC]);
      rnd_max[a] = $signed(sum_max[ACC_W-1:MAT_FRAC]);
      if (rnd_min[a] < CLAMP_LO) begin
        clp_min[a] = CLAMP_LO[COORD_WIDTH-1:0];
        sat_any    = 1'b1;
      end else if (rnd_min[a] > CLAMP_HI) begin
        clp_min[a] = CLAMP_HI[COORD_WIDTH-1:0];
        sat_any    = 1'b1;
      end else begin
        clp_min[a] = rnd_min[a][COORD_WIDTH-1:0];
      end
      if (rnd_max[a] > CLAMP_HI) begin
        clp_max[a] = CLAMP_HI[COORD_WIDTH-1:0];
        sat_any    = 1'b1;
      end else if (rnd_max[a] < CLAMP_LO) begin
        clp_max[a] = CLAMP_LO[COORD_WIDTH-1:0];
        sat_any    = 1'b1;
      end else begin
        clp_max[a] = rnd_max[a][COORD_WIDTH-1:0];
      end
    end
  end

  // Stage 4: output register
  always_ff @(posedge clk) begin
    result.out_min_x <= clp_min[0];
    result.out_max_x <= clp_max[0];
    result.out_min_y <= clp_min[1];
    result.out_max_y <= clp_max[1];
    result.out_min_z <= clp_min[2];
    result.out_max_z <= clp_max[2];
    result.saturated <= sat_any;
  end

endmodule
`default_nettype wire
